// File: rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the program stream video extractor
// Item structs, parser phases, start code values and register map.
// ----------------------------------------------------------------------------
package pse_pkg;

  // Default saturation limit of the per-buffer payload count
  localparam int unsigned PSE_MAX_FRAME_BYTES = 1048575;

  // Register map (byte addresses)
  localparam int          PSE_ADDR_W        = 3;
  localparam logic [31:0] PSE_VID_ID_RESET  = 32'h0000_00E0;

  // Stream syntax
  localparam logic [23:0] PSE_START_PREFIX  = 24'h00_0001;
  localparam logic [7:0]  PSE_STREAM_MAP_ID = 8'hBC;
  localparam logic [3:0]  PSE_PACK_LAST_IDX = 4'd13;   // index of last pack header byte
  localparam logic [2:0]  PSE_CODE_BYTES    = 3'd4;
  localparam logic [1:0]  PSE_LEN_BYTES     = 2'd2;
  localparam logic [1:0]  PSE_PES_HDR_BYTES = 2'd3;

  // Stop reason codes
  localparam logic [1:0]  PSE_STOP_END      = 2'd0;
  localparam logic [1:0]  PSE_STOP_UNKNOWN  = 2'd1;
  localparam logic [1:0]  PSE_STOP_SHORT    = 2'd2;

  typedef enum logic [3:0] {
    PH_PACK      = 4'd0,
    PH_PSTUFF    = 4'd1,
    PH_FIRST     = 4'd2,
    PH_CODE      = 4'd3,
    PH_PES_LEN   = 4'd4,
    PH_PES_HDR   = 4'd5,
    PH_PES_STUFF = 4'd6,
    PH_PAYLOAD   = 4'd7,
    PH_MAP_LEN   = 4'd8,
    PH_MAP_BODY  = 4'd9
  } pse_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } pse_in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        frame_end;
    logic [19:0] frame_length;
    logic [1:0]  stop_reason;
  } pse_out_t;

endpackage

// File: rtl/program_stream_video_extractor.sv
// ----------------------------------------------------------------------------
// program_stream_video_extractor
// Walks one program stream buffer a byte per item and emits the payload bytes
// of the selected video PES packets, plus a frame summary on the last byte.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                 payload
//  -------   ---   -----------------------   ---------------------------------
//  in        in    in_valid / in_stall       in_data  (byte, first, last)
//  out       out   out_valid / out_stall     out_data (byte, valid, end, len,
//                                                      reason)
//  cfg       in    APB psel/penable/pwrite   video_stream_id at byte addr 0
//
//  One item per cycle while in_stall is low: parser state and result (if any)
//  are registered at the edge the item is taken; the result is offered from
//  the next cycle, or waits in the skid register while the output is held.
//  The per-byte work is a handful of counter decrements and compares.
//  A skid register behind the output register absorbs one result while
//  out_stall is high; in_stall is raised only while that skid slot is full.
//  Reset (rst, synchronous) returns the parser to the pack header phase and
//  the stream id register to 0xE0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module program_stream_video_extractor #(
  parameter int unsigned MAX_FRAME_BYTES = pse_pkg::PSE_MAX_FRAME_BYTES
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pse_pkg::pse_in_t                  in_data,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output pse_pkg::pse_out_t                 out_data,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pse_pkg::PSE_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import pse_pkg::*;

  // Width of the saturating payload counter
  localparam int CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_BYTES);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [7:0] video_stream_id;
  logic       cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PSE_ADDR_W-1] == 1'b0);   // register 0 occupies bytes 0..3

  always_ff @(posedge clk) begin
    if (rst) begin
      video_stream_id <= PSE_VID_ID_RESET[7:0];
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      video_stream_id <= pwdata[7:0];
    end
  end

  assign prdata = cfg_hit ? {24'd0, video_stream_id} : 32'd0;

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  pse_phase_t      phase,       phase_next;
  logic [3:0]      field_cnt,   field_cnt_next;   // up to 13 in the pack header
  logic [23:0]     code_win,    code_win_next;    // last three code bytes
  logic [15:0]     pkt_len,     pkt_len_next;
  logic [7:0]      skip_left,   skip_left_next;
  logic [15:0]     pay_left,    pay_left_next;
  logic            halted,      halted_next;
  logic [CntW-1:0] emitted,     emitted_next;

  // Values after this byte is taken, before the end-of-buffer restart
  pse_phase_t      step_phase;
  logic            step_halted;

  // State seen by the current byte: a first byte restarts the parser first
  pse_phase_t      cur_phase;
  logic [3:0]      cur_field_cnt;
  logic [23:0]     cur_code_win;
  logic [15:0]     cur_pkt_len;
  logic [7:0]      cur_skip_left;
  logic [15:0]     cur_pay_left;
  logic            cur_halted;
  logic [CntW-1:0] cur_emitted;

  logic            in_fire;
  logic [7:0]      b;

  assign in_fire = in_valid && !in_stall;
  assign b       = in_data.data_byte;

  always_comb begin
    if (in_data.first_byte) begin
      cur_phase     = PH_PACK;
      cur_field_cnt = '0;
      cur_code_win  = '0;
      cur_pkt_len   = '0;
      cur_skip_left = '0;
      cur_pay_left  = '0;
      cur_halted    = 1'b0;
      cur_emitted   = '0;
    end else begin
      cur_phase     = phase;
      cur_field_cnt = field_cnt;
      cur_code_win  = code_win;
      cur_pkt_len   = pkt_len;
      cur_skip_left = skip_left;
      cur_pay_left  = pay_left;
      cur_halted    = halted;
      cur_emitted   = emitted;
    end
  end

  // Next state: take one byte
  always_comb begin
    logic [15:0] len_shift;
    logic [17:0] pay_calc;     // signed length - 3 - header data length
    logic        code_video;
    logic        code_map;

    step_phase     = cur_phase;
    field_cnt_next = cur_field_cnt;
    code_win_next  = cur_code_win;
    pkt_len_next   = cur_pkt_len;
    skip_left_next = cur_skip_left;
    pay_left_next  = cur_pay_left;
    step_halted    = cur_halted;
    emitted_next   = cur_emitted;

    len_shift  = {cur_pkt_len[7:0], b};
    pay_calc   = {2'b00, cur_pkt_len} - 18'd3 - {10'd0, b};
    code_video = (cur_code_win == PSE_START_PREFIX) && (b == video_stream_id);
    code_map   = (cur_code_win == PSE_START_PREFIX) && (b == PSE_STREAM_MAP_ID);

    if (!cur_halted) begin
      unique case (cur_phase)
        PH_PACK: begin
          if (cur_field_cnt >= PSE_PACK_LAST_IDX) begin
            skip_left_next = {5'd0, b[2:0]};
            field_cnt_next = '0;
            step_phase     = (b[2:0] != 3'd0) ? PH_PSTUFF : PH_FIRST;
          end else begin
            field_cnt_next = cur_field_cnt + 4'd1;
          end
        end
        PH_PSTUFF: begin
          skip_left_next = cur_skip_left - 8'd1;
          if (skip_left_next == 8'd0) begin
            field_cnt_next = '0;
            step_phase     = PH_FIRST;
          end
        end
        PH_FIRST, PH_CODE: begin
          code_win_next  = {cur_code_win[15:0], b};
          field_cnt_next = cur_field_cnt + 4'd1;
          if (field_cnt_next >= {1'b0, PSE_CODE_BYTES}) begin
            field_cnt_next = '0;
            if (code_video) begin
              step_phase   = PH_PES_LEN;
              pkt_len_next = '0;
            end else if (code_map) begin
              step_phase   = PH_MAP_LEN;
              pkt_len_next = '0;
            end else begin
              step_halted  = 1'b1;
            end
          end
        end
        PH_PES_LEN, PH_MAP_LEN: begin
          pkt_len_next   = len_shift;
          field_cnt_next = cur_field_cnt + 4'd1;
          if (field_cnt_next >= {2'b00, PSE_LEN_BYTES}) begin
            field_cnt_next = '0;
            if (cur_phase == PH_PES_LEN) begin
              step_phase = PH_PES_HDR;
            end else if (len_shift == 16'd0) begin
              step_phase = PH_CODE;
            end else begin
              pay_left_next = len_shift;
              step_phase    = PH_MAP_BODY;
            end
          end
        end
        PH_PES_HDR: begin
          field_cnt_next = cur_field_cnt + 4'd1;
          if (field_cnt_next >= {2'b00, PSE_PES_HDR_BYTES}) begin
            // Non-positive payload length means an empty packet
            pay_left_next  = (pay_calc[17] || pay_calc == 18'd0) ? 16'd0 : pay_calc[15:0];
            skip_left_next = b;
            field_cnt_next = '0;
            if (b != 8'd0) begin
              step_phase = PH_PES_STUFF;
            end else begin
              step_phase = (pay_left_next != 16'd0) ? PH_PAYLOAD : PH_CODE;
            end
          end
        end
        PH_PES_STUFF: begin
          skip_left_next = cur_skip_left - 8'd1;
          if (skip_left_next == 8'd0) begin
            step_phase     = (cur_pay_left != 16'd0) ? PH_PAYLOAD : PH_CODE;
            field_cnt_next = '0;
          end
        end
        PH_PAYLOAD, PH_MAP_BODY: begin
          pay_left_next = cur_pay_left - 16'd1;
          if (pay_left_next == 16'd0) begin
            step_phase     = PH_CODE;
            field_cnt_next = '0;
          end
          if (cur_phase == PH_PAYLOAD && cur_emitted < CntMax) begin
            emitted_next = cur_emitted + CntW'(1);
          end
        end
        default: begin
          step_halted = 1'b1;
        end
      endcase
    end

    phase_next  = step_phase;
    halted_next = step_halted;
  end

  // Result of this byte
  pse_out_t res;
  logic     res_make;

  always_comb begin
    logic [CntW+19:0] len_ext;

    len_ext          = {20'd0, emitted_next};
    res.byte_valid   = !cur_halted && (cur_phase == PH_PAYLOAD);
    res.payload_byte = res.byte_valid ? b : 8'd0;
    res.frame_end    = in_data.last_byte;
    res.frame_length = in_data.last_byte ? len_ext[19:0] : 20'd0;
    if (!in_data.last_byte) begin
      res.stop_reason = PSE_STOP_END;
    end else if (step_halted) begin
      res.stop_reason = PSE_STOP_UNKNOWN;
    end else if (step_phase == PH_PACK || step_phase == PH_PSTUFF || step_phase == PH_FIRST) begin
      res.stop_reason = PSE_STOP_SHORT;
    end else begin
      res.stop_reason = PSE_STOP_END;
    end
    res_make = res.byte_valid || in_data.last_byte;
  end

  // State registers; the last byte of a buffer restarts the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_PACK;
      field_cnt <= '0;
      code_win  <= '0;
      pkt_len   <= '0;
      skip_left <= '0;
      pay_left  <= '0;
      halted    <= 1'b0;
      emitted   <= '0;
    end else if (in_fire) begin
      if (in_data.last_byte) begin
        phase     <= PH_PACK;
        field_cnt <= '0;
        code_win  <= '0;
        pkt_len   <= '0;
        skip_left <= '0;
        pay_left  <= '0;
        halted    <= 1'b0;
        emitted   <= '0;
      end else begin
        phase     <= phase_next;
        field_cnt <= field_cnt_next;
        code_win  <= code_win_next;
        pkt_len   <= pkt_len_next;
        skip_left <= skip_left_next;
        pay_left  <= pay_left_next;
        halted    <= halted_next;
        emitted   <= emitted_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register with one skid slot
  // --------------------------------------------------------------------------
  logic     skid_valid;
  pse_out_t skid_data;

  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid  <= in_fire && res_make;
        end
      end else if (in_fire && res_make) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire && res_make) begin
        out_data <= res;
      end
    end else if (in_fire && res_make) begin
      skid_data <= res;
    end
  end

`ifndef SYNTHESIS
  // The skid slot only fills behind a held output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output register empty");

  // Every delivered result carries a byte or a frame end
  a_no_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.byte_valid || out_data.frame_end))
    else $error("empty result item");

  // Summary fields stay zero outside the frame end result
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.frame_end) |->
      (out_data.frame_length == 20'd0 && out_data.stop_reason == PSE_STOP_END))
    else $error("frame summary set on a non-final result");

  // Last byte leaves the parser at the pack header with a cleared count
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.last_byte) |=>
      (phase == PH_PACK && !halted && emitted == '0))
    else $error("parser not restarted after last byte");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the program stream video extractor
// Feeds program stream buffers a byte per item and checks every result item
// against a behavioral parser kept in the bench. A short directed table opens
// the run. Random buffers follow under several stream id settings: mostly
// well-formed pack headers, stream maps and video PES packets, plus noise and
// cut-off buffers. Both channels idle at random, and the receiver once holds
// off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
  import pse_pkg::*;

  localparam logic [PSE_ADDR_W-1:0] VID_ID_ADDR = '0;   // video_stream_id register
  localparam int WATCHDOG_CYCLES = 400000;
  localparam int DRAIN_CYCLES    = 8;      // output reg + skid, with margin
  localparam int PHASE_ITEMS     = 45;     // minimum random items per stream id setting
  localparam int PRESSURE_AT     = 150;    // items taken before the long hold-off
  localparam int PRESSURE_CYCLES = 300;

  // per-item note: a directed row may carry its expected result typed in
  typedef struct packed {
    logic     fixed;
    pse_out_t want;
  } item_note_t;

  typedef struct packed {
    pse_in_t  it;
    logic     fixed;
    pse_out_t want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pse_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pse_out_t              out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PSE_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  program_stream_video_extractor dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Parser model: bench copy of the stream id register and the parse state
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_video_id;
  pse_phase_t  ps_phase;
  logic [15:0] ps_count;      // bytes seen in the current field
  logic [31:0] ps_window;     // last four bytes of a start code
  logic [15:0] ps_pkt_len;
  logic [7:0]  ps_skip;       // stuffing / header data still to drop
  logic [15:0] ps_left;       // payload or map body still to come
  logic        ps_halted;
  logic [19:0] ps_emitted;

  pse_out_t   pending_video_results[$];
  item_note_t sent_item_notes[$];
  dir_row_t   dir_rows[$];
  logic [7:0] stream_bytes[$];

  int mismatch_count = 0;
  int fed_items      = 0;
  int phase_items    = 0;
  int cycle_count    = 0;

  function automatic void parser_clear();
    ps_phase   = PH_PACK;
    ps_count   = '0;
    ps_window  = '0;
    ps_pkt_len = '0;
    ps_skip    = '0;
    ps_left    = '0;
    ps_halted  = 1'b0;
    ps_emitted = '0;
  endfunction

  function automatic void leave_pes_header();
    if (ps_left != 0) ps_phase = PH_PAYLOAD;
    else ps_phase = PH_CODE;
    ps_count = '0;
  endfunction

  // advance the parser by one byte; 1 when the byte is video payload
  function automatic logic step_parser(input logic [7:0] b);
    int pay;
    if (ps_halted) return 1'b0;
    case (ps_phase)
      PH_PACK: begin
        if (ps_count >= PSE_PACK_LAST_IDX) begin
          ps_skip  = {5'd0, b[2:0]};
          ps_count = '0;
          if (b[2:0] != 0) ps_phase = PH_PSTUFF;
          else ps_phase = PH_FIRST;
        end else begin
          ps_count++;
        end
      end
      PH_PSTUFF: begin
        ps_skip = ps_skip - 8'd1;
        if (ps_skip == 0) begin
          ps_count = '0;
          ps_phase = PH_FIRST;
        end
      end
      PH_FIRST, PH_CODE: begin
        ps_window = {ps_window[23:0], b};
        ps_count++;
        if (ps_count >= PSE_CODE_BYTES) begin
          ps_count = '0;
          // the video id wins even when it equals the stream map id
          if (ps_window[31:8] == PSE_START_PREFIX && ps_window[7:0] == cfg_video_id) begin
            ps_phase   = PH_PES_LEN;
            ps_pkt_len = '0;
          end else if (ps_window == {PSE_START_PREFIX, PSE_STREAM_MAP_ID}) begin
            ps_phase   = PH_MAP_LEN;
            ps_pkt_len = '0;
          end else begin
            ps_halted = 1'b1;
          end
        end
      end
      PH_PES_LEN, PH_MAP_LEN: begin
        ps_pkt_len = {ps_pkt_len[7:0], b};
        ps_count++;
        if (ps_count >= PSE_LEN_BYTES) begin
          ps_count = '0;
          if (ps_phase == PH_PES_LEN) begin
            ps_phase = PH_PES_HDR;
          end else if (ps_pkt_len == 0) begin
            ps_phase = PH_CODE;
          end else begin
            ps_left  = ps_pkt_len;
            ps_phase = PH_MAP_BODY;
          end
        end
      end
      PH_PES_HDR: begin
        ps_count++;
        if (ps_count >= PSE_PES_HDR_BYTES) begin
          // third header byte is the header data length
          pay     = int'(ps_pkt_len) - 3 - int'(b);
          ps_left = (pay > 0) ? pay[15:0] : 16'd0;
          ps_skip = b;
          if (b != 0) ps_phase = PH_PES_STUFF;
          else leave_pes_header();
          ps_count = '0;
        end
      end
      PH_PES_STUFF: begin
        ps_skip = ps_skip - 8'd1;
        if (ps_skip == 0) leave_pes_header();
      end
      PH_PAYLOAD: begin
        ps_left = ps_left - 16'd1;
        if (ps_left == 0) begin
          ps_phase = PH_CODE;
          ps_count = '0;
        end
        if (ps_emitted < PSE_MAX_FRAME_BYTES) ps_emitted++;
        return 1'b1;
      end
      PH_MAP_BODY: begin
        ps_left = ps_left - 16'd1;
        if (ps_left == 0) begin
          ps_phase = PH_CODE;
          ps_count = '0;
        end
      end
      default: ps_halted = 1'b1;
    endcase
    return 1'b0;
  endfunction

  function automatic pse_out_t mk_result(input logic [7:0] b, input logic v, input logic fe,
                                         input logic [19:0] len, input logic [1:0] why);
    pse_out_t r;
    r.payload_byte = b;
    r.byte_valid   = v;
    r.frame_end    = fe;
    r.frame_length = len;
    r.stop_reason  = why;
    return r;
  endfunction

  // expected result of one byte; 0 when the byte makes no result
  function automatic logic predict_video_result(input pse_in_t it, output pse_out_t r);
    logic       shown;
    logic [1:0] why;
    r = '0;
    if (it.first_byte) parser_clear();
    shown = step_parser(it.data_byte);
    if (!shown && !it.last_byte) return 1'b0;
    if (shown) r = mk_result(it.data_byte, 1'b1, 1'b0, '0, PSE_STOP_END);
    if (it.last_byte) begin
      if (ps_halted) why = PSE_STOP_UNKNOWN;
      else if (ps_phase == PH_PACK || ps_phase == PH_PSTUFF || ps_phase == PH_FIRST)
        why = PSE_STOP_SHORT;
      else why = PSE_STOP_END;
      r.frame_end    = 1'b1;
      r.frame_length = ps_emitted;
      r.stop_reason  = why;
      parser_clear();   // next byte starts a new buffer either way
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checker: predict on every accepted input item, compare every result item
  // ---------------------------------------------------------------------------
  task automatic field_mismatch(input string name, input logic [31:0] want,
                                input logic [31:0] got);
    $error("%s: expected %0d, got %0d", name, want, got);
    mismatch_count++;
  endtask

  task automatic check_video_result(input pse_out_t want, input pse_out_t got);
    if (got.payload_byte !== want.payload_byte)
      field_mismatch("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
    if (got.byte_valid !== want.byte_valid)
      field_mismatch("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
    if (got.frame_end !== want.frame_end)
      field_mismatch("frame_end", 32'(want.frame_end), 32'(got.frame_end));
    if (got.frame_length !== want.frame_length)
      field_mismatch("frame_length", 32'(want.frame_length), 32'(got.frame_length));
    if (got.stop_reason !== want.stop_reason)
      field_mismatch("stop_reason", 32'(want.stop_reason), 32'(got.stop_reason));
  endtask

  item_note_t taken_note;
  pse_out_t   model_result;
  logic       model_has_result;

  // Inputs change by NBA at the edge, so this block sees pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        taken_note = (sent_item_notes.size() != 0) ? sent_item_notes.pop_front() : '0;
        model_has_result = predict_video_result(in_data, model_result);
        // a typed-in row overrides the model's view of that byte
        if (taken_note.fixed) pending_video_results.push_back(taken_note.want);
        else if (model_has_result) pending_video_results.push_back(model_result);
        fed_items++;
      end
      if (out_valid && !out_stall) begin
        if (pending_video_results.size() == 0) begin
          $error("result with nothing expected: byte %0d valid %0d end %0d",
                 out_data.payload_byte, out_data.byte_valid, out_data.frame_end);
          mismatch_count++;
        end else begin
          check_video_result(pending_video_results.pop_front(), out_data);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > WATCHDOG_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall runs of random length, one long hold-off to fill the block
  // ---------------------------------------------------------------------------
  logic pressure_done = 1'b0;

  initial begin
    @(posedge clk);
    forever begin
      if (!pressure_done && fed_items >= PRESSURE_AT) begin
        // sender keeps offering meanwhile, so in_stall has to rise
        out_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        out_stall <= 1'b0;
        repeat (($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(20, 80))
          @(posedge clk);
        out_stall <= 1'b1;
        repeat (($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40))
          @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and config port; all tasks are entered just after a rising edge
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one item and return at the edge that takes it; valid stays high
  // across back-to-back items
  task automatic send_item(input pse_in_t it, input logic fixed, input pse_out_t want,
                           input logic calm);
    item_note_t n;
    int         gap;
    n.fixed = fixed;
    n.want  = want;
    sent_item_notes.push_back(n);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let everything expected come out, plus the pipeline depth for items
  // that make no result
  task automatic wait_idle();
    @(posedge clk);
    while (pending_video_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VID_ID_ADDR;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);   // register takes the write at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_video_id = value;
    @(posedge clk);
  endtask

  task automatic reg_read_check(input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= VID_ID_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);   // access phase just ended; prdata seen pre-edge
    if (prdata[7:0] !== want)
      field_mismatch("video_stream_id", 32'(want), 32'(prdata[7:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  task automatic add_row(input logic [7:0] b, input logic f, input logic l,
                         input logic fixed, input pse_out_t want);
    dir_row_t row;
    row.it.data_byte  = b;
    row.it.first_byte = f;
    row.it.last_byte  = l;
    row.fixed         = fixed;
    row.want          = want;
    dir_rows.push_back(row);
  endtask

  // 14-byte pack header; the last byte's low 3 bits are the stuffing count
  task automatic add_pack_header(input logic f, input logic [7:0] tail, input logic l,
                                 input logic fixed, input pse_out_t want);
    logic [7:0] body[13];
    int         i;
    body = '{8'h00, 8'h00, 8'h01, 8'hBA, 8'h44, 8'hFF, 8'h00, 8'hFF, 8'h00,
             8'hFF, 8'h00, 8'hFF, 8'h03};
    for (i = 0; i < 13; i++) add_row(body[i], (i == 0) ? f : 1'b0, 1'b0, 1'b0, '0);
    add_row(tail, 1'b0, l, fixed, want);
  endtask

  task automatic fill_directed();
    // one-byte buffer: both flags on one item, too short
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, mk_result(8'h00, 1'b0, 1'b1, 20'd0, PSE_STOP_SHORT));
    // header, stream map, video PES with two payload bytes, then unknown code
    add_pack_header(1'b1, 8'hF8, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
    add_row(PSE_STREAM_MAP_ID, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hAB, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
    add_row(PSE_VID_ID_RESET[7:0], 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h05, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b1, mk_result(8'h00, 1'b1, 1'b0, 20'd0, PSE_STOP_END));
    add_row(8'hFF, 1'b0, 1'b0, 1'b1, mk_result(8'hFF, 1'b1, 1'b0, 20'd0, PSE_STOP_END));
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hC0, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h5A, 1'b0, 1'b1, 1'b1, mk_result(8'h00, 1'b0, 1'b1, 20'd2, PSE_STOP_UNKNOWN));
    // no first flag: the parser restarted on the last byte; buffer ends
    // right after the header
    add_pack_header(1'b0, 8'h00, 1'b1, 1'b1,
                    mk_result(8'h00, 1'b0, 1'b1, 20'd0, PSE_STOP_SHORT));
  endtask

  // ---------------------------------------------------------------------------
  // Random buffers
  // ---------------------------------------------------------------------------
  task automatic push_random(input int n);
    repeat (n) stream_bytes.push_back(rand_byte());
  endtask

  task automatic push_code(input logic [7:0] id);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h01);
    stream_bytes.push_back(id);
  endtask

  task automatic build_buffer();
    int         stuff, pkts, kind, plen, hlen, pay, cut, i;
    logic [7:0] tail;
    logic [15:0] len16;
    logic        done;
    stream_bytes.delete();
    // noise buffer
    if ($urandom_range(0, 9) == 0) begin
      push_random($urandom_range(1, 30));
      return;
    end
    push_random(13);
    stuff = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    tail  = rand_byte();
    stream_bytes.push_back({tail[7:3], 3'(stuff)});
    push_random(stuff);
    pkts = $urandom_range(0, 4);
    done = 1'b0;
    for (i = 0; i < pkts && !done; i++) begin
      kind = $urandom_range(0, 14);
      if (kind <= 9) begin
        // video PES; length may undercut its own header (empty payload)
        push_code(cfg_video_id);
        hlen  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
        plen  = (kind == 9) ? $urandom_range(256, 65535) : $urandom_range(0, 16);
        len16 = plen[15:0];
        stream_bytes.push_back(len16[15:8]);
        stream_bytes.push_back(len16[7:0]);
        push_random(2);
        stream_bytes.push_back(8'(hlen));
        push_random(hlen);
        if (kind == 9) begin
          // long packet cut off by the end of the buffer
          push_random($urandom_range(0, 10));
          done = 1'b1;
        end else begin
          pay = plen - 3 - hlen;
          if (pay > 0) push_random(pay);
        end
      end else if (kind <= 12) begin
        push_code(PSE_STREAM_MAP_ID);
        plen = $urandom_range(0, 6);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'(plen));
        push_random(plen);
      end else if (kind == 13) begin
        // random stream id, usually unknown; bytes after an unknown one are ignored
        push_code(rand_byte());
        push_random($urandom_range(0, 5));
        done = 1'b1;
      end else begin
        push_random($urandom_range(4, 7));
        done = 1'b1;
      end
    end
    // cut the buffer anywhere, including inside a start code
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, stream_bytes.size());
      while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
    end
  endtask

  task automatic send_buffer();
    pse_in_t it;
    logic    lead, calm;
    int      i;
    lead = ($urandom_range(0, 7) != 0);   // else rely on the restart after last
    calm = ($urandom_range(0, 3) == 0);   // whole buffer back to back
    for (i = 0; i < stream_bytes.size(); i++) begin
      it.data_byte  = stream_bytes[i];
      it.first_byte = (i == 0) ? lead : ($urandom_range(0, 149) == 0);
      it.last_byte  = (i == stream_bytes.size() - 1);
      send_item(it, 1'b0, '0, calm);
      phase_items++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int         phase, i;
    logic [7:0] next_id;
    cfg_video_id = PSE_VID_ID_RESET[7:0];
    parser_clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    fill_directed();
    for (i = 0; i < dir_rows.size(); i++)
      send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].want,
                ($urandom_range(0, 1) == 0));
    in_valid <= 1'b0;
    wait_idle();
    reg_read_check(PSE_VID_ID_RESET[7:0]);

    // stream id settings: reset value, both extremes, the map id, random, back
    for (phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        case (phase)
          1:       next_id = 8'h00;
          2:       next_id = 8'hFF;
          3:       next_id = PSE_STREAM_MAP_ID;
          4:       next_id = rand_byte();
          default: next_id = PSE_VID_ID_RESET[7:0];
        endcase
        reg_write(next_id);
        reg_read_check(next_id);
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_buffer();
        send_buffer();
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
